[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/spp_pkg.sv]
`default_nettype none

package spp_pkg;

  typedef enum logic [3:0] {
    PH_ORDER   = 4'd0,
    PH_PAD3    = 4'd1,
    PH_SERIAL  = 4'd2,
    PH_COUNT   = 4'd3,
    PH_TYPE    = 4'd4,
    PH_TPAD    = 4'd5,
    PH_NLEN    = 4'd6,
    PH_NAME    = 4'd7,
    PH_NPAD    = 4'd8,
    PH_ESERIAL = 4'd9,
    PH_IVAL    = 4'd10,
    PH_SLEN    = 4'd11,
    PH_SDATA   = 4'd12,
    PH_SPAD    = 4'd13,
    PH_COLOR   = 4'd14,
    PH_HALT    = 4'd15
  } phase_t;

  localparam logic [2:0] KIND_NAME  = 3'd0;
  localparam logic [2:0] KIND_STR   = 3'd1;
  localparam logic [2:0] KIND_ENTRY = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  localparam logic [1:0] ERR_TRUNC     = 2'd0;
  localparam logic [1:0] ERR_BYTEORDER = 2'd1;
  localparam logic [1:0] ERR_ZERO      = 2'd2;
  localparam logic [1:0] ERR_TYPE      = 2'd3;

  localparam logic [7:0] TYPE_INT   = 8'd0;
  localparam logic [7:0] TYPE_STR   = 8'd1;
  localparam logic [7:0] TYPE_COLOR = 8'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         entry_type;
    logic [7:0]         text_byte;
    logic [31:0]        entry_serial;
    logic signed [31:0] signed_value;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        alpha;
    logic [1:0]         error_code;
    logic [31:0]        entry_count;
  } result_t;

endpackage

`default_nettype wire

[rtl/settings_property_parser_unit.sv]
// Settings property parser.
// Input channel (in_valid/in_ready): one property byte per item, data_byte
// plus last_byte marking the final byte of the property.
// Output channel (out_valid/out_ready): result items -- name bytes, string
// bytes, an entry record per completed entry, a done record, or an error
// record after which the rest of the property is dropped.
// A result is written into the result queue register when its byte is
// accepted. Throughput: one byte per cycle while in_ready is high; the
// per-byte parse update is a single pass of logic on the parser state. A
// byte that yields two results (last entry plus done, or a record plus a
// truncation error) puts both into the three-entry result queue, and
// in_ready drops while the queue holds more than one item.
// in_ready is high while the queue holds at most one item, so it comes from
// a register and never from out_ready.
// When the receiver stalls, the queue fills and in_ready drops; nothing is
// lost. Reset empties the queue and puts the parser back to expecting a
// byte-order byte.
`default_nettype none

module settings_property_parser_unit (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [7:0]        data_byte,
  input  wire               last_byte,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [2:0]        kind,
  output logic [1:0]        entry_type,
  output logic [7:0]        text_byte,
  output logic [31:0]       entry_serial,
  output logic signed [31:0] signed_value,
  output logic [15:0]       red,
  output logic [15:0]       green,
  output logic [15:0]       blue,
  output logic [15:0]       alpha,
  output logic [1:0]        error_code,
  output logic [31:0]       entry_count
);
  import spp_pkg::*;

  localparam int QDepth = 3;

  // Parser state
  phase_t      phase, phase_next;
  logic        big_endian, big_endian_next;
  logic [1:0]  byte_in_field, byte_in_field_next;
  logic [31:0] field_word, field_word_next;
  logic [31:0] entries_left, entries_left_next;
  logic [31:0] total_entries, total_entries_next;
  logic [31:0] copy_left, copy_left_next;
  logic [1:0]  pad_left, pad_left_next;
  logic [7:0]  current_type, current_type_next;
  logic [31:0] current_serial, current_serial_next;
  logic [63:0] value_bits, value_bits_next;

  // Result queue, head at index 0
  result_t     q [QDepth];
  logic [1:0]  q_cnt;

  logic        push, pop;
  logic [1:0]  n_res;
  result_t     r0, r1;

  // Per-byte combinational pieces
  logic [31:0] fw_base, fw_take;
  logic [1:0]  k_inc;
  logic [1:0]  type_out;
  logic        main_v, done_v, trunc_v;
  result_t     main_r, done_r, trunc_r;
  logic        fin, fin_carry;
  logic [63:0] fin_vb;
  logic [2:0]  color_idx;
  logic [2:0]  lane;
  logic [31:0] dec_copy;
  logic [1:0]  dec_pad;

  assign in_ready  = (q_cnt <= 2'd1);
  assign out_valid = (q_cnt != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  assign type_out = (current_type <= TYPE_COLOR) ? current_type[1:0] : 2'd0;

  // Field assembly in the announced byte order
  assign fw_base   = (byte_in_field == 2'd0) ? 32'd0 : field_word;
  assign fw_take   = big_endian ? {fw_base[23:0], data_byte}
                                : (fw_base | ({24'd0, data_byte} << {byte_in_field, 3'b000}));
  assign k_inc     = byte_in_field + 2'd1;
  assign dec_copy  = copy_left - 32'd1;
  assign dec_pad   = pad_left - 2'd1;
  assign color_idx = copy_left[2:0];
  assign lane      = {color_idx[2:1], color_idx[0] ^ big_endian};

  always_comb begin
    phase_next          = phase;
    big_endian_next     = big_endian;
    byte_in_field_next  = byte_in_field;
    field_word_next     = field_word;
    entries_left_next   = entries_left;
    total_entries_next  = total_entries;
    copy_left_next      = copy_left;
    pad_left_next       = pad_left;
    current_type_next   = current_type;
    current_serial_next = current_serial;
    value_bits_next     = value_bits;
    main_v    = 1'b0;
    done_v    = 1'b0;
    trunc_v   = 1'b0;
    main_r    = '0;
    done_r    = '0;
    trunc_r   = '0;
    fin       = 1'b0;
    fin_carry = 1'b0;
    fin_vb    = value_bits;

    unique case (phase)
      PH_ORDER: begin
        byte_in_field_next = 2'd0;
        if (data_byte > 8'd1) begin
          main_v             = 1'b1;
          main_r.kind        = KIND_ERROR;
          main_r.error_code  = ERR_BYTEORDER;
          phase_next         = PH_HALT;
        end else begin
          big_endian_next = data_byte[0];
          phase_next      = PH_PAD3;
        end
      end
      PH_PAD3: begin
        field_word_next = fw_take;
        if (byte_in_field == 2'd2) begin
          byte_in_field_next = 2'd0;
          phase_next         = PH_SERIAL;
        end else begin
          byte_in_field_next = k_inc;
        end
      end
      PH_SERIAL: begin
        field_word_next    = fw_take;
        byte_in_field_next = k_inc;
        if (byte_in_field == 2'd3) phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        field_word_next    = fw_take;
        byte_in_field_next = k_inc;
        if (byte_in_field == 2'd3) begin
          if (fw_take == 32'd0) begin
            main_v            = 1'b1;
            main_r.kind       = KIND_ERROR;
            main_r.error_code = ERR_ZERO;
            phase_next        = PH_HALT;
          end else begin
            total_entries_next = fw_take;
            entries_left_next  = fw_take;
            phase_next         = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        current_type_next = data_byte;
        phase_next        = PH_TPAD;
      end
      PH_TPAD: begin
        phase_next = PH_NLEN;
      end
      PH_NLEN: begin
        field_word_next = fw_take;
        if (byte_in_field == 2'd1) begin
          byte_in_field_next = 2'd0;
          copy_left_next     = {16'd0, fw_take[15:0]};
          pad_left_next      = 2'd0 - fw_take[1:0];
          phase_next         = (fw_take[15:0] != 16'd0) ? PH_NAME : PH_ESERIAL;
        end else begin
          byte_in_field_next = k_inc;
        end
      end
      PH_NAME: begin
        main_v            = 1'b1;
        main_r.kind       = KIND_NAME;
        main_r.entry_type = type_out;
        main_r.text_byte  = data_byte;
        copy_left_next    = dec_copy;
        if (dec_copy == 32'd0) phase_next = (pad_left != 2'd0) ? PH_NPAD : PH_ESERIAL;
      end
      PH_NPAD: begin
        pad_left_next = dec_pad;
        if (dec_pad == 2'd0) phase_next = PH_ESERIAL;
      end
      PH_ESERIAL: begin
        field_word_next    = fw_take;
        byte_in_field_next = k_inc;
        if (byte_in_field == 2'd3) begin
          current_serial_next = fw_take;
          value_bits_next     = 64'd0;
          case (current_type)
            TYPE_INT:   phase_next = PH_IVAL;
            TYPE_STR:   phase_next = PH_SLEN;
            TYPE_COLOR: begin
              copy_left_next = 32'd0;
              phase_next     = PH_COLOR;
            end
            default: begin
              main_v            = 1'b1;
              main_r.kind       = KIND_ERROR;
              main_r.error_code = ERR_TYPE;
              phase_next        = PH_HALT;
            end
          endcase
        end
      end
      PH_IVAL: begin
        field_word_next    = fw_take;
        byte_in_field_next = k_inc;
        if (byte_in_field == 2'd3) begin
          value_bits_next = {32'd0, fw_take};
          fin_vb          = {32'd0, fw_take};
          fin             = 1'b1;
        end
      end
      PH_SLEN: begin
        field_word_next    = fw_take;
        byte_in_field_next = k_inc;
        if (byte_in_field == 2'd3) begin
          if (fw_take == 32'hFFFF_FFFF) begin
            main_v            = 1'b1;
            main_r.kind       = KIND_ERROR;
            main_r.error_code = ERR_TRUNC;
            phase_next        = PH_HALT;
          end else begin
            copy_left_next = fw_take;
            pad_left_next  = 2'd0 - fw_take[1:0];
            if (fw_take == 32'd0) fin = 1'b1;
            else phase_next = PH_SDATA;
          end
        end
      end
      PH_SDATA: begin
        copy_left_next = dec_copy;
        if (dec_copy == 32'd0 && pad_left == 2'd0) begin
          // length a multiple of four: last byte rides in the entry record
          fin       = 1'b1;
          fin_carry = 1'b1;
        end else begin
          main_v            = 1'b1;
          main_r.kind       = KIND_STR;
          main_r.entry_type = type_out;
          main_r.text_byte  = data_byte;
          if (dec_copy == 32'd0) phase_next = PH_SPAD;
        end
      end
      PH_SPAD: begin
        pad_left_next = dec_pad;
        if (dec_pad == 2'd0) fin = 1'b1;
      end
      PH_COLOR: begin
        value_bits_next[{lane, 3'b000} +: 8] = value_bits[{lane, 3'b000} +: 8] | data_byte;
        fin_vb         = value_bits_next;
        copy_left_next = {29'd0, color_idx} + 32'd1;
        if (color_idx == 3'd7) fin = 1'b1;
      end
      PH_HALT: begin
      end
      default: begin
      end
    endcase

    if (fin) begin
      main_v              = 1'b1;
      main_r.kind         = KIND_ENTRY;
      main_r.entry_type   = type_out;
      main_r.entry_serial = current_serial;
      main_r.text_byte    = fin_carry ? data_byte : 8'd0;
      if (current_type == TYPE_INT) begin
        main_r.signed_value = fin_vb[31:0];
      end else if (current_type == TYPE_COLOR) begin
        main_r.red   = fin_vb[15:0];
        main_r.green = fin_vb[31:16];
        main_r.blue  = fin_vb[47:32];
        main_r.alpha = fin_vb[63:48];
      end
      entries_left_next = entries_left - 32'd1;
      if (entries_left_next == 32'd0) begin
        done_v             = 1'b1;
        done_r.kind        = KIND_DONE;
        done_r.entry_count = total_entries;
        phase_next         = PH_HALT;
      end else begin
        phase_next = PH_TYPE;
      end
    end

    // End of property: anything short of done/error is a truncation
    if (last_byte) begin
      if (phase_next != PH_HALT) begin
        trunc_v            = 1'b1;
        trunc_r.kind       = KIND_ERROR;
        trunc_r.error_code = ERR_TRUNC;
      end
      phase_next         = PH_ORDER;
      byte_in_field_next = 2'd0;
    end
  end

  // Order: phase record, then done, then truncation; at most two at once
  assign r0    = main_v ? main_r : trunc_r;
  assign r1    = done_v ? done_r : trunc_r;
  assign n_res = {1'b0, main_v} + {1'b0, done_v} + {1'b0, trunc_v};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ORDER;
      big_endian     <= 1'b0;
      byte_in_field  <= 2'd0;
      field_word     <= 32'd0;
      entries_left   <= 32'd0;
      total_entries  <= 32'd0;
      copy_left      <= 32'd0;
      pad_left       <= 2'd0;
      current_type   <= 8'd0;
      current_serial <= 32'd0;
      value_bits     <= 64'd0;
    end else if (push) begin
      phase          <= phase_next;
      big_endian     <= big_endian_next;
      byte_in_field  <= byte_in_field_next;
      field_word     <= field_word_next;
      entries_left   <= entries_left_next;
      total_entries  <= total_entries_next;
      copy_left      <= copy_left_next;
      pad_left       <= pad_left_next;
      current_type   <= current_type_next;
      current_serial <= current_serial_next;
      value_bits     <= value_bits_next;
    end
  end

  // Result queue: shift toward the head on pop, append at the tail
  logic [1:0] n_push;
  logic [1:0] q_base;

  assign n_push = push ? n_res : 2'd0;
  assign q_base = q_cnt - {1'b0, pop};

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) begin
      if (n_push != 2'd0 && q_base == 2'(i)) begin
        q[i] <= r0;
      end else if (n_push == 2'd2 && (q_base + 2'd1) == 2'(i)) begin
        q[i] <= r1;
      end else if (pop && i < QDepth - 1) begin
        q[i] <= q[(i < QDepth - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_base + n_push;
    end
  end

  assign kind         = q[0].kind;
  assign entry_type   = q[0].entry_type;
  assign text_byte    = q[0].text_byte;
  assign entry_serial = q[0].entry_serial;
  assign signed_value = q[0].signed_value;
  assign red          = q[0].red;
  assign green        = q[0].green;
  assign blue         = q[0].blue;
  assign alpha        = q[0].alpha;
  assign error_code   = q[0].error_code;
  assign entry_count  = q[0].entry_count;

endmodule

`default_nettype wire

[rtl/spp_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module spp_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  kind,
  input wire [31:0] entry_serial,
  input wire [1:0]  error_code,
  input wire [31:0] entry_count
);
  import spp_pkg::*;

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // only defined result kinds leave the block
  `ASSERT_IMPL(a_kind_range, clk, rst, out_valid, kind <= KIND_ERROR)
  // done never reports an empty property
  `ASSERT_IMPL(a_done_count, clk, rst, out_valid && kind == KIND_DONE, entry_count != 32'd0)
  // serial only shows on entry records, error code only on error records
  `ASSERT_IMPL(a_field_zero, clk, rst, out_valid && kind != KIND_ENTRY,
               entry_serial == 32'd0 && (kind == KIND_ERROR || error_code == 2'd0))
  // empty queue and no byte arriving: the input side is open next cycle
  `ASSERT_NEXT(a_in_open, clk, rst, !out_valid && !in_valid, in_ready)

endmodule

bind settings_property_parser_unit spp_checker u_spp_checker (.*);

`default_nettype wire
